// ===== design/lto_pkg.sv =====
// ----------------------------------------------------------------------------
// lto_pkg: shared types, codes and microcode for the line table opcode encoder
// Holds the word formats, the control word layout and the sequencer program.
// ----------------------------------------------------------------------------
package lto_pkg;

    // input word: one line-table item
    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] code_offset;
        logic [15:0] file_index;
        logic [23:0] line_number;
        logic [15:0] column_number;
        logic [63:0] start_address;
        logic [31:0] function_size;
    } lto_in_t;

    // output word: one program byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } lto_out_t;

    // item operations
    localparam logic [1:0] OPER_ROW    = 2'd0;
    localparam logic [1:0] OPER_FSTART = 2'd1;
    localparam logic [1:0] OPER_FEND   = 2'd2;
    localparam logic [1:0] OPER_EOS    = 2'd3;

    // line program opcodes
    localparam logic [7:0] LNE_ESCAPE       = 8'h00;
    localparam logic [7:0] LNE_END_SEQ      = 8'h01;
    localparam logic [7:0] LNE_SET_ADDRESS  = 8'h02;
    localparam logic [7:0] LNS_COPY         = 8'h01;
    localparam logic [7:0] LNS_ADVANCE_PC   = 8'h02;
    localparam logic [7:0] LNS_ADVANCE_LINE = 8'h03;
    localparam logic [7:0] LNS_SET_FILE     = 8'h04;
    localparam logic [7:0] LNS_SET_COLUMN   = 8'h05;

    // special opcode parameters
    localparam int LINE_BASE     = -4;
    localparam int LINE_RANGE    = 12;
    localparam int OPCODE_BASE   = 13;
    localparam int SPECIAL_LIMIT = 255;

    // pointer width limits and reset value
    localparam logic [3:0] PTR_MIN   = 4'd4;
    localparam logic [3:0] PTR_MAX   = 4'd8;
    localparam logic [3:0] PTR_RESET = 4'd8;

    // byte source select
    localparam logic [2:0] EM_NONE    = 3'd0;
    localparam logic [2:0] EM_CONST   = 3'd1;
    localparam logic [2:0] EM_LEB     = 3'd2;
    localparam logic [2:0] EM_ADDR    = 3'd3;
    localparam logic [2:0] EM_SPECIAL = 3'd4;
    localparam logic [2:0] EM_PTRLEN  = 3'd5;

    // leb128 load source
    localparam logic [2:0] LB_NONE   = 3'd0;
    localparam logic [2:0] LB_FILE   = 3'd1;
    localparam logic [2:0] LB_COL    = 3'd2;
    localparam logic [2:0] LB_ADELTA = 3'd3;
    localparam logic [2:0] LB_LDELTA = 3'd4;

    // skip conditions
    localparam logic [2:0] SK_NEVER      = 3'd0;
    localparam logic [2:0] SK_SAME_FILE  = 3'd1;
    localparam logic [2:0] SK_SAME_COL   = 3'd2;
    localparam logic [2:0] SK_NO_SPECIAL = 3'd3;
    localparam logic [2:0] SK_AD_ZERO    = 3'd4;
    localparam logic [2:0] SK_LD_ZERO    = 3'd5;

    // state actions at step completion
    localparam logic [1:0] AC_NONE   = 2'd0;
    localparam logic [1:0] AC_ROW    = 2'd1;
    localparam logic [1:0] AC_FSTART = 2'd2;
    localparam logic [1:0] AC_EOS    = 2'd3;

    // next step selection
    localparam logic [1:0] NX_SEQ      = 2'd0;
    localparam logic [1:0] NX_DISPATCH = 2'd1;
    localparam logic [1:0] NX_END      = 2'd2;

    // program addresses
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] ST_WAIT     = 5'd0;
    localparam logic [PC_W-1:0] ST_FILE     = 5'd1;
    localparam logic [PC_W-1:0] ST_FILE_VAL = 5'd2;
    localparam logic [PC_W-1:0] ST_COL      = 5'd3;
    localparam logic [PC_W-1:0] ST_COL_VAL  = 5'd4;
    localparam logic [PC_W-1:0] ST_SPECIAL  = 5'd5;
    localparam logic [PC_W-1:0] ST_APC      = 5'd6;
    localparam logic [PC_W-1:0] ST_APC_VAL  = 5'd7;
    localparam logic [PC_W-1:0] ST_ALN      = 5'd8;
    localparam logic [PC_W-1:0] ST_ALN_VAL  = 5'd9;
    localparam logic [PC_W-1:0] ST_COPY     = 5'd10;
    localparam logic [PC_W-1:0] ST_FS_ESC   = 5'd11;
    localparam logic [PC_W-1:0] ST_FS_LEN   = 5'd12;
    localparam logic [PC_W-1:0] ST_FS_OP    = 5'd13;
    localparam logic [PC_W-1:0] ST_FS_ADDR  = 5'd14;
    localparam logic [PC_W-1:0] ST_FE_OP    = 5'd15;
    localparam logic [PC_W-1:0] ST_FE_VAL   = 5'd16;
    localparam logic [PC_W-1:0] ST_ES_ESC   = 5'd17;
    localparam logic [PC_W-1:0] ST_ES_LEN   = 5'd18;
    localparam logic [PC_W-1:0] ST_ES_OP    = 5'd19;
    localparam logic [PC_W-1:0] ST_LAST     = 5'd19;

    // control word
    typedef struct packed {
        logic            wait_in;
        logic [2:0]      emit;
        logic [7:0]      byte_val;
        logic [2:0]      leb_sel;
        logic [2:0]      skip;
        logic [PC_W-1:0] target;
        logic            loop;
        logic            last;
        logic [1:0]      act;
        logic [1:0]      nx;
    } lto_ctl_t;

    // step strobes from sequencer to datapath
    typedef struct packed {
        logic accept;
        logic step_en;
        logic emit_en;
        logic done;
    } lto_cmd_t;

    // datapath flags for jumps and loops
    typedef struct packed {
        logic same_file;
        logic same_col;
        logic no_special;
        logic ad_zero;
        logic ld_zero;
        logic leb_done;
        logic addr_done;
    } lto_status_t;

    function automatic lto_ctl_t ctl_word(
        input logic            wait_in,
        input logic [2:0]      emit,
        input logic [7:0]      byte_val,
        input logic [2:0]      leb_sel,
        input logic [2:0]      skip,
        input logic [PC_W-1:0] target,
        input logic            loop,
        input logic            last,
        input logic [1:0]      act,
        input logic [1:0]      nx
    );
        lto_ctl_t c;
        c.wait_in  = wait_in;
        c.emit     = emit;
        c.byte_val = byte_val;
        c.leb_sel  = leb_sel;
        c.skip     = skip;
        c.target   = target;
        c.loop     = loop;
        c.last     = last;
        c.act      = act;
        c.nx       = nx;
        return c;
    endfunction

    // microcode program
    function automatic lto_ctl_t lto_rom(input logic [PC_W-1:0] pc);
        lto_ctl_t c;
        case (pc)
            ST_WAIT:
                c = ctl_word(1'b1, EM_NONE, 8'h00, LB_NONE, SK_NEVER, ST_WAIT,
                             1'b0, 1'b0, AC_NONE, NX_DISPATCH);
            ST_FILE:
                c = ctl_word(1'b0, EM_CONST, LNS_SET_FILE, LB_FILE, SK_SAME_FILE, ST_COL,
                             1'b0, 1'b0, AC_NONE, NX_SEQ);
            ST_FILE_VAL:
                c = ctl_word(1'b0, EM_LEB, 8'h00, LB_NONE, SK_NEVER, ST_WAIT,
                             1'b1, 1'b0, AC_NONE, NX_SEQ);
            ST_COL:
                c = ctl_word(1'b0, EM_CONST, LNS_SET_COLUMN, LB_COL, SK_SAME_COL,
                             ST_SPECIAL, 1'b0, 1'b0, AC_NONE, NX_SEQ);
            ST_COL_VAL:
                c = ctl_word(1'b0, EM_LEB, 8'h00, LB_NONE, SK_NEVER, ST_WAIT,
                             1'b1, 1'b0, AC_NONE, NX_SEQ);
            ST_SPECIAL:
                c = ctl_word(1'b0, EM_SPECIAL, 8'h00, LB_NONE, SK_NO_SPECIAL, ST_APC,
                             1'b0, 1'b1, AC_ROW, NX_END);
            ST_APC:
                c = ctl_word(1'b0, EM_CONST, LNS_ADVANCE_PC, LB_ADELTA, SK_AD_ZERO,
                             ST_ALN, 1'b0, 1'b0, AC_NONE, NX_SEQ);
            ST_APC_VAL:
                c = ctl_word(1'b0, EM_LEB, 8'h00, LB_NONE, SK_NEVER, ST_WAIT,
                             1'b1, 1'b0, AC_NONE, NX_SEQ);
            ST_ALN:
                c = ctl_word(1'b0, EM_CONST, LNS_ADVANCE_LINE, LB_LDELTA, SK_LD_ZERO,
                             ST_COPY, 1'b0, 1'b0, AC_NONE, NX_SEQ);
            ST_ALN_VAL:
                c = ctl_word(1'b0, EM_LEB, 8'h00, LB_NONE, SK_NEVER, ST_WAIT,
                             1'b1, 1'b0, AC_NONE, NX_SEQ);
            ST_COPY:
                c = ctl_word(1'b0, EM_CONST, LNS_COPY, LB_NONE, SK_NEVER, ST_WAIT,
                             1'b0, 1'b1, AC_ROW, NX_END);
            ST_FS_ESC:
                c = ctl_word(1'b0, EM_CONST, LNE_ESCAPE, LB_NONE, SK_NEVER, ST_WAIT,
                             1'b0, 1'b0, AC_NONE, NX_SEQ);
            ST_FS_LEN:
                c = ctl_word(1'b0, EM_PTRLEN, 8'h00, LB_NONE, SK_NEVER, ST_WAIT,
                             1'b0, 1'b0, AC_NONE, NX_SEQ);
            ST_FS_OP:
                c = ctl_word(1'b0, EM_CONST, LNE_SET_ADDRESS, LB_NONE, SK_NEVER, ST_WAIT,
                             1'b0, 1'b0, AC_NONE, NX_SEQ);
            ST_FS_ADDR:
                c = ctl_word(1'b0, EM_ADDR, 8'h00, LB_NONE, SK_NEVER, ST_WAIT,
                             1'b1, 1'b1, AC_FSTART, NX_END);
            ST_FE_OP:
                c = ctl_word(1'b0, EM_CONST, LNS_ADVANCE_PC, LB_ADELTA, SK_NEVER, ST_WAIT,
                             1'b0, 1'b0, AC_NONE, NX_SEQ);
            ST_FE_VAL:
                c = ctl_word(1'b0, EM_LEB, 8'h00, LB_NONE, SK_NEVER, ST_WAIT,
                             1'b1, 1'b1, AC_NONE, NX_END);
            ST_ES_ESC:
                c = ctl_word(1'b0, EM_CONST, LNE_ESCAPE, LB_NONE, SK_NEVER, ST_WAIT,
                             1'b0, 1'b0, AC_NONE, NX_SEQ);
            ST_ES_LEN:
                c = ctl_word(1'b0, EM_CONST, 8'h01, LB_NONE, SK_NEVER, ST_WAIT,
                             1'b0, 1'b0, AC_NONE, NX_SEQ);
            ST_ES_OP:
                c = ctl_word(1'b0, EM_CONST, LNE_END_SEQ, LB_NONE, SK_NEVER, ST_WAIT,
                             1'b0, 1'b1, AC_EOS, NX_END);
            default:
                c = ctl_word(1'b0, EM_NONE, 8'h00, LB_NONE, SK_NEVER, ST_WAIT,
                             1'b0, 1'b0, AC_NONE, NX_END);
        endcase
        return c;
    endfunction

    // entry point of each operation
    function automatic logic [PC_W-1:0] lto_dispatch(input logic [1:0] oper);
        logic [PC_W-1:0] t;
        case (oper)
            OPER_ROW:    t = ST_FILE;
            OPER_FSTART: t = ST_FS_ESC;
            OPER_FEND:   t = ST_FE_OP;
            OPER_EOS:    t = ST_ES_ESC;
            default:     t = ST_WAIT;
        endcase
        return t;
    endfunction

    // pointer width limited to the legal range
    function automatic logic [3:0] lto_clamp_ptr(input logic [3:0] v);
        logic [3:0] r;
        r = v;
        if (v < PTR_MIN) r = PTR_MIN;
        if (v > PTR_MAX) r = PTR_MAX;
        return r;
    endfunction

endpackage

// ===== design/lto_seq.sv =====
// ----------------------------------------------------------------------------
// lto_seq: microcode sequencer
// Step counter, program lookup, skip and loop evaluation, step strobes.
// ----------------------------------------------------------------------------
module lto_seq
    import lto_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [1:0]  oper,
    input  logic        out_free,
    input  lto_status_t stat,
    output logic        in_ready,
    output lto_ctl_t    ctl,
    output lto_cmd_t    cmd
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            skip_hit;
    logic            need_slot;
    logic            loop_done;
    logic            stall;

    // current control word
    assign ctl = lto_rom(pc_reg);

    // skip condition
    always_comb
    begin
        case (ctl.skip)
            SK_NEVER:      skip_hit = 1'b0;
            SK_SAME_FILE:  skip_hit = stat.same_file;
            SK_SAME_COL:   skip_hit = stat.same_col;
            SK_NO_SPECIAL: skip_hit = stat.no_special;
            SK_AD_ZERO:    skip_hit = stat.ad_zero;
            SK_LD_ZERO:    skip_hit = stat.ld_zero;
            default:       skip_hit = 1'b0;
        endcase
    end

    // step strobes
    assign need_slot   = (ctl.emit != EM_NONE);
    assign loop_done   = (ctl.emit == EM_ADDR) ? stat.addr_done : stat.leb_done;
    assign stall       = (ctl.wait_in && !in_valid) || (need_slot && !out_free && !skip_hit);
    assign cmd.step_en = !stall && !skip_hit;
    assign cmd.emit_en = cmd.step_en && need_slot;
    assign cmd.done    = cmd.step_en && (!ctl.loop || loop_done);
    assign cmd.accept  = cmd.step_en && ctl.wait_in;
    assign in_ready    = ctl.wait_in;

    // next step
    always_comb
    begin
        pc_next = pc_reg;
        if (!stall)
        begin
            if (skip_hit)
            begin
                pc_next = ctl.target;
            end
            else if (cmd.done)
            begin
                case (ctl.nx)
                    NX_SEQ:      pc_next = pc_reg + PC_W'(1);
                    NX_DISPATCH: pc_next = lto_dispatch(oper);
                    NX_END:      pc_next = ST_WAIT;
                    default:     pc_next = ST_WAIT;
                endcase
            end
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

`ifndef SYNTHESIS
    // the last word of an item returns the program to the wait step
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.done && ctl.last |=> pc_reg == ST_WAIT)
        else $error("lto_seq: program did not end after last word");

    // program counter stays inside the program
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= ST_LAST)
        else $error("lto_seq: step counter out of program");

    // an unfinished loop holds its step
    a_loop_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_en && ctl.loop && !loop_done |=> $stable(pc_reg))
        else $error("lto_seq: loop step left early");
`endif

endmodule

// ===== design/lto_dp.sv =====
// ----------------------------------------------------------------------------
// lto_dp: encoder datapath
// Item capture and deltas, line state, leb128 and address shifters, output
// register.
// ----------------------------------------------------------------------------
module lto_dp
    import lto_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lto_in_t     in_data,
    input  logic        cfg_valid,
    input  logic [3:0]  cfg_data,
    input  lto_ctl_t    ctl,
    input  lto_cmd_t    cmd,
    input  logic        out_ready,
    output lto_status_t stat,
    output logic        out_free,
    output logic        out_valid,
    output lto_out_t    out_data
);

    // line state and config
    logic [31:0] cur_address_reg, cur_address_next;
    logic [16:0] cur_file_reg, cur_file_next;
    logic [23:0] cur_line_reg, cur_line_next;
    logic [15:0] cur_column_reg, cur_column_next;
    logic [3:0]  ptr_reg, ptr_next;
    logic        out_valid_reg, out_valid_next;

    // captured item
    logic [16:0]        file_reg;
    logic [23:0]        line_reg;
    logic [15:0]        col_reg;
    logic [31:0]        offset_reg;
    logic [31:0]        adelta_reg;
    logic signed [24:0] ldelta_reg;
    logic               same_file_reg;
    logic               same_col_reg;
    logic               same_line_reg;
    logic               special_reg;
    logic [7:0]         spec_reg;
    logic [63:0]        addr_reg;
    logic [3:0]         cnt_reg;
    logic [32:0]        leb_reg;
    logic               leb_signed_reg;
    lto_out_t           out_data_reg;

    // accept-time arithmetic
    logic [16:0]        file_in;
    logic [31:0]        minuend;
    logic [31:0]        adelta;
    logic signed [24:0] ldelta;
    logic [24:0]        ld_bias;
    logic               same_file;
    logic               same_line;
    logic [15:0]        col_val;
    logic               ld_in_range;
    logic [8:0]         spec_sum;
    logic               special;

    // leb128 byte forming
    logic [32:0] leb_rest;
    logic        leb_done;
    logic [7:0]  leb_byte;
    logic [7:0]  emit_byte;

    // deltas and row decisions from the incoming word
    always_comb
    begin
        file_in     = {1'b0, in_data.file_index} + 17'd1;
        minuend     = (in_data.operation == OPER_FEND) ? in_data.function_size
                                                       : in_data.code_offset;
        adelta      = minuend - cur_address_reg;
        ldelta      = $signed({1'b0, in_data.line_number}) - $signed({1'b0, cur_line_reg});
        ld_bias     = ldelta - 25'(LINE_BASE);
        same_file   = (file_in == cur_file_reg);
        same_line   = (in_data.line_number == cur_line_reg);
        col_val     = (same_file && same_line) ? in_data.column_number : 16'd0;
        ld_in_range = (ld_bias[24:4] == '0) && (ld_bias[3:0] < 4'(LINE_RANGE));
        // address delta times twelve as two shifts
        spec_sum    = ({4'b0, adelta[4:0]} << 3) + ({4'b0, adelta[4:0]} << 2)
                    + {5'b0, ld_bias[3:0]} + 9'(OPCODE_BASE);
        special     = (adelta[31:5] == '0) && ld_in_range && (spec_sum < 9'(SPECIAL_LIMIT));
    end

    // leb128 next byte and termination
    always_comb
    begin
        leb_rest = $signed(leb_reg) >>> 7;
        if (leb_signed_reg)
        begin
            leb_done = ((leb_rest == '0) && !leb_reg[6]) || ((leb_rest == '1) && leb_reg[6]);
        end
        else
        begin
            leb_done = (leb_rest == '0);
        end
        leb_byte = {!leb_done, leb_reg[6:0]};
    end

    // byte source select
    always_comb
    begin
        case (ctl.emit)
            EM_CONST:   emit_byte = ctl.byte_val;
            EM_LEB:     emit_byte = leb_byte;
            EM_ADDR:    emit_byte = addr_reg[7:0];
            EM_SPECIAL: emit_byte = spec_reg;
            EM_PTRLEN:  emit_byte = {4'b0, cnt_reg} + 8'd1;
            default:    emit_byte = 8'h00;
        endcase
    end

    // line state, config and output valid next values
    always_comb
    begin
        cur_address_next = cur_address_reg;
        cur_file_next    = cur_file_reg;
        cur_line_next    = cur_line_reg;
        cur_column_next  = cur_column_reg;
        ptr_next         = ptr_reg;
        out_valid_next   = out_valid_reg;
        if (cmd.done)
        begin
            case (ctl.act)
                AC_ROW:
                begin
                    cur_address_next = offset_reg;
                    cur_file_next    = file_reg;
                    cur_line_next    = line_reg;
                    cur_column_next  = col_reg;
                end
                AC_FSTART:
                begin
                    cur_address_next = 32'd0;
                end
                AC_EOS:
                begin
                    cur_address_next = 32'd0;
                    cur_file_next    = 17'd1;
                    cur_line_next    = 24'd1;
                    cur_column_next  = 16'd0;
                end
                default:
                begin
                    cur_address_next = cur_address_reg;
                end
            endcase
        end
        if (cfg_valid)
        begin
            ptr_next = cfg_data;
        end
        if (cmd.emit_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_address_reg <= 32'd0;
            cur_file_reg    <= 17'd1;
            cur_line_reg    <= 24'd1;
            cur_column_reg  <= 16'd0;
            ptr_reg         <= PTR_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            cur_address_reg <= cur_address_next;
            cur_file_reg    <= cur_file_next;
            cur_line_reg    <= cur_line_next;
            cur_column_reg  <= cur_column_next;
            ptr_reg         <= ptr_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // item capture, shifters and output word
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            file_reg      <= file_in;
            line_reg      <= in_data.line_number;
            col_reg       <= col_val;
            offset_reg    <= in_data.code_offset;
            adelta_reg    <= adelta;
            ldelta_reg    <= ldelta;
            same_file_reg <= same_file;
            same_col_reg  <= (col_val == cur_column_reg);
            same_line_reg <= same_line;
            special_reg   <= special;
            spec_reg      <= spec_sum[7:0];
            addr_reg      <= in_data.start_address;
            cnt_reg       <= lto_clamp_ptr(ptr_reg);
        end
        if (cmd.step_en)
        begin
            case (ctl.leb_sel)
                LB_FILE:
                begin
                    leb_reg        <= {16'b0, file_reg};
                    leb_signed_reg <= 1'b0;
                end
                LB_COL:
                begin
                    leb_reg        <= {17'b0, col_reg};
                    leb_signed_reg <= 1'b0;
                end
                LB_ADELTA:
                begin
                    leb_reg        <= {1'b0, adelta_reg};
                    leb_signed_reg <= 1'b0;
                end
                LB_LDELTA:
                begin
                    leb_reg        <= {{8{ldelta_reg[24]}}, ldelta_reg};
                    leb_signed_reg <= 1'b1;
                end
                default:
                begin
                    if (ctl.emit == EM_LEB)
                    begin
                        leb_reg <= leb_rest;
                    end
                end
            endcase
        end
        if (cmd.emit_en && (ctl.emit == EM_ADDR))
        begin
            addr_reg <= addr_reg >> 8;
            cnt_reg  <= cnt_reg - 4'd1;
        end
        if (cmd.emit_en)
        begin
            out_data_reg.out_byte  <= emit_byte;
            out_data_reg.last_byte <= ctl.last && cmd.done;
        end
    end

    // status to the sequencer
    assign stat.same_file  = same_file_reg;
    assign stat.same_col   = same_col_reg;
    assign stat.no_special = !special_reg;
    assign stat.ad_zero    = (adelta_reg == 32'd0);
    assign stat.ld_zero    = same_line_reg;
    assign stat.leb_done   = leb_done;
    assign stat.addr_done  = (cnt_reg == 4'd1);

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // address bytes are sent only while some remain
    a_addr_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_en && (ctl.emit == EM_ADDR) |-> cnt_reg != 4'd0)
        else $error("lto_dp: address byte count underflow");

    // a special opcode goes out only when it was found legal
    a_special_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_en && (ctl.emit == EM_SPECIAL) |-> special_reg && (spec_reg != 8'hff))
        else $error("lto_dp: illegal special opcode sent");

    // end of sequence returns the line state to its start values
    a_eos_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.done && (ctl.act == AC_EOS)
        |=> (cur_file_reg == 17'd1) && (cur_line_reg == 24'd1) && (cur_address_reg == 32'd0))
        else $error("lto_dp: line state not restored at end of sequence");
`endif

endmodule

// ===== design/line_table_opcode_encoder.sv =====
// ----------------------------------------------------------------------------
// line_table_opcode_encoder: line number program byte encoder
// Turns line-table items into line program opcode bytes, one byte per word.
// ----------------------------------------------------------------------------
// After acceptance, every opcode checked and skipped takes one step before the first byte is
// sent; each sent byte is held in the output register, and output stalls delay it.
// Throughput: one microcode step per cycle unless the input or output stalls: one to take the
// item, one per byte sent and one per opcode checked and skipped.
// Reset: asynchronous, active low; line state to address 0, file 1, line 1.
module line_table_opcode_encoder
    import lto_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  lto_in_t    in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output lto_out_t   out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data
);

    lto_ctl_t    ctl;
    lto_cmd_t    cmd;
    lto_status_t stat;
    logic        out_free;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    // sequencer
    lto_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .oper     (in_data.operation),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (in_ready),
        .ctl      (ctl),
        .cmd      (cmd)
    );

    // datapath
    lto_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .cmd       (cmd),
        .out_ready (out_ready),
        .stat      (stat),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: line table opcode encoder check
// Drives line-table words through the encoder with random sender bursts and
// receiver stalls, predicts the line program bytes in the testbench and
// compares every byte and last flag in order, over several pointer widths.
// ----------------------------------------------------------------------------
module testbench;
    import lto_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 6;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_WORDS  = 46;
    localparam logic [7:0] ES_LENGTH = 8'h01;

    // one stimulus row; typed bytes are right aligned, first byte highest
    typedef struct packed {
        lto_in_t      item;
        logic [4:0]   n_typed;
        logic [127:0] typed;
    } stim_t;

    typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PULSED} rx_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    lto_in_t    in_data;
    logic       out_valid;
    logic       out_ready = 1'b0;
    lto_out_t   out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [3:0] cfg_data = 4'd0;

    stim_t cur_word = '0;
    assign in_data = cur_word.item;

    line_table_opcode_encoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock and reset
    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
    end

    // line state shadow and pointer width
    logic [31:0] ln_address = 32'd0;
    logic [16:0] ln_file    = 17'd1;
    logic [23:0] ln_line    = 24'd1;
    logic [15:0] ln_column  = 16'd0;
    logic [3:0]  ptr_width  = PTR_RESET;

    logic [7:0] staged[$];
    lto_out_t   program_bytes[$];

    int mismatches    = 0;
    int bytes_checked = 0;
    int words_sent    = 0;
    int op_seen[4]    = '{0, 0, 0, 0};
    int widths_used   = 1;

    function automatic void put_uleb(input logic [31:0] v);
        logic [7:0] b;
        do
        begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            if (v != 32'd0)
                b[7] = 1'b1;
            staged.push_back(b);
        end
        while (v != 32'd0);
    endfunction

    function automatic void put_sleb(input int v);
        logic [7:0] b;
        bit         done;
        do
        begin
            b = {1'b0, v[6:0]};
            v = v >>> 7;
            done = (v == 0 && !b[6]) || (v == -1 && b[6]);
            if (!done)
                b[7] = 1'b1;
            staged.push_back(b);
        end
        while (!done);
    endfunction

    // bytes of one row, line state updated in program order
    function automatic void encode_row(input lto_in_t w);
        logic [16:0] file;
        logic [31:0] adelta;
        logic [15:0] col;
        int          ldelta;
        longint      special;
        file   = {1'b0, w.file_index} + 17'd1;
        adelta = w.code_offset - ln_address;
        ldelta = $signed({8'd0, w.line_number}) - $signed({8'd0, ln_line});
        col    = (file == ln_file && ldelta == 0) ? w.column_number : 16'd0;
        if (file != ln_file)
        begin
            staged.push_back(LNS_SET_FILE);
            put_uleb({15'd0, file});
            ln_file = file;
        end
        if (col != ln_column)
        begin
            staged.push_back(LNS_SET_COLUMN);
            put_uleb({16'd0, col});
            ln_column = col;
        end
        ln_address = w.code_offset;
        ln_line    = w.line_number;
        special = longint'({32'd0, adelta}) * LINE_RANGE + (ldelta - LINE_BASE) + OPCODE_BASE;
        // one special opcode covers both deltas when it fits
        if (ldelta >= LINE_BASE && ldelta < LINE_BASE + LINE_RANGE && special < SPECIAL_LIMIT)
        begin
            staged.push_back(special[7:0]);
            return;
        end
        if (adelta != 32'd0)
        begin
            staged.push_back(LNS_ADVANCE_PC);
            put_uleb(adelta);
        end
        if (ldelta != 0)
        begin
            staged.push_back(LNS_ADVANCE_LINE);
            put_sleb(ldelta);
        end
        staged.push_back(LNS_COPY);
    endfunction

    function automatic void encode_word(input lto_in_t w);
        logic [3:0] pb;
        case (w.operation)
            OPER_ROW:
                encode_row(w);
            OPER_FSTART:
            begin
                pb = ptr_width;
                if (pb < 4'd4)
                    pb = 4'd4;
                if (pb > 4'd8)
                    pb = 4'd8;
                staged.push_back(LNE_ESCAPE);
                staged.push_back({4'd0, pb} + 8'd1);
                staged.push_back(LNE_SET_ADDRESS);
                for (int i = 0; i < pb; i++)
                    staged.push_back(w.start_address[8*i +: 8]);
                ln_address = 32'd0;
            end
            OPER_FEND:
            begin
                staged.push_back(LNS_ADVANCE_PC);
                put_uleb(w.function_size - ln_address);
            end
            default:
            begin
                staged.push_back(LNE_ESCAPE);
                staged.push_back(ES_LENGTH);
                staged.push_back(LNE_END_SEQ);
                ln_address = 32'd0;
                ln_file    = 17'd1;
                ln_line    = 24'd1;
                ln_column  = 16'd0;
            end
        endcase
    endfunction

    // predict on accepted words, check accepted bytes, track config writes
    always @(posedge clk)
    begin : monitor
        int       n;
        lto_out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (program_bytes.size() == 0)
                begin
                    $error("unexpected byte %h (last %b)", out_data.out_byte,
                           out_data.last_byte);
                    mismatches++;
                end
                else
                begin
                    want = program_bytes.pop_front();
                    bytes_checked++;
                    if (out_data.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, got %h", want.out_byte,
                               out_data.out_byte);
                        mismatches++;
                    end
                    if (out_data.last_byte !== want.last_byte)
                    begin
                        $error("last_byte: expected %b, got %b", want.last_byte,
                               out_data.last_byte);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                staged.delete();
                encode_word(cur_word.item);
                op_seen[cur_word.item.operation]++;
                n = int'(cur_word.n_typed);
                // hand-written bytes take the place of the prediction
                if (n != 0)
                begin
                    staged.delete();
                    for (int i = 0; i < n; i++)
                        staged.push_back(cur_word.typed[8*(n-1-i) +: 8]);
                end
                foreach (staged[i])
                    program_bytes.push_back('{out_byte: staged[i],
                                              last_byte: (i == staged.size() - 1)});
            end
            if (cfg_valid && cfg_ready)
                ptr_width = cfg_data;
        end
    end

    // watchdog on cycles without any handshake
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stall pattern
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_tick = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(3));
                rx_left = $urandom_range(20, 150);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_MOSTLY: out_ready <= ($urandom_range(3) != 0);
                RX_SPARSE: out_ready <= ($urandom_range(3) == 0);
                default:   out_ready <= ((rx_tick % 8) < 3);
            endcase
        end
    end

    function automatic stim_t make_word(input logic [1:0] op, input logic [31:0] off,
                                        input logic [15:0] fidx, input logic [23:0] line,
                                        input logic [15:0] col, input logic [63:0] saddr,
                                        input logic [31:0] fsize, input int n,
                                        input logic [127:0] typed);
        stim_t s;
        s.item.operation     = op;
        s.item.code_offset   = off;
        s.item.file_index    = fidx;
        s.item.line_number   = line;
        s.item.column_number = col;
        s.item.start_address = saddr;
        s.item.function_size = fsize;
        s.n_typed            = n[4:0];
        s.typed              = typed;
        return s;
    endfunction

    // sender: bursts of words with idle gaps; called at a falling edge
    int burst_left = 0;

    task automatic send_word(input stim_t s);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(4) == 0) ? 40 : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        cur_word <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
        burst_left--;
        if (burst_left == 0)
            in_valid <= 1'b0;
    endtask

    task automatic end_burst();
        if (burst_left != 0)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
        end
    endtask

    // hold the sender until every predicted byte is out
    task automatic wait_drained();
        while (program_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_ptr_width(input logic [3:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random well-formed function: start, rows, end, maybe end of sequence
    logic [23:0] gen_line = 24'd1;
    logic [15:0] gen_file = 16'd0;

    task automatic send_function();
        logic [31:0] off;
        logic [15:0] col;
        logic [31:0] fsize;
        int          pick;
        int          step;
        int          nrows;
        off = 32'd0;
        send_word(make_word(OPER_FSTART, $urandom, 16'($urandom_range(65534)),
                            24'($urandom), 16'($urandom), {$urandom, $urandom},
                            $urandom, 0, '0));
        nrows = $urandom_range(1, 8);
        for (int r = 0; r < nrows; r++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                off = off + $urandom_range(20);
            else if (pick < 92)
                off = off + $urandom_range(21, 400);
            else
                off = $urandom;
            pick = $urandom_range(99);
            if (pick < 60)
                step = int'($urandom_range(11)) - 4;
            else if (pick < 75)
                step = 0;
            else if (pick < 92)
                step = int'($urandom_range(4000)) - 2000;
            else
                step = int'($urandom & 32'h00ff_ffff) - int'(gen_line);
            gen_line = 24'(int'(gen_line) + step);
            pick = $urandom_range(99);
            if (pick >= 97)
                gen_file = 16'($urandom_range(65534));
            else if (pick >= 85)
                gen_file = 16'($urandom_range(7));
            col = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(80));
            send_word(make_word(OPER_ROW, off, gen_file, gen_line, col,
                                {$urandom, $urandom}, $urandom, 0, '0));
        end
        fsize = ($urandom_range(9) == 0) ? $urandom : off + $urandom_range(64);
        send_word(make_word(OPER_FEND, $urandom, 16'($urandom_range(65534)), 24'($urandom),
                            16'($urandom), {$urandom, $urandom}, fsize, 0, '0));
        if ($urandom_range(9) < 3)
            send_word(make_word(OPER_EOS, $urandom, 16'($urandom_range(65534)),
                                24'($urandom), 16'($urandom), {$urandom, $urandom},
                                $urandom, 0, '0));
    endtask

    // any operation with every field random
    task automatic send_noise();
        send_word(make_word(2'($urandom_range(3)), $urandom, 16'($urandom_range(65534)),
                            24'($urandom), 16'($urandom), {$urandom, $urandom},
                            $urandom, 0, '0));
    endtask

    stim_t      directed[$];
    logic [3:0] ptr_settings[9] = '{4'd4, 4'd15, 4'd0, 4'd7, 4'd9, 4'd5, 4'd3, 4'd6, 4'd8};

    // main sequence
    initial
    begin : stimulus
        int target;
        // directed words, hand-written bytes where they are obvious
        directed.push_back(make_word(OPER_ROW, 32'd0, 16'd0, 24'd1, 16'd0, 64'd0, 32'd0,
                                     1, 128'h11));
        directed.push_back(make_word(OPER_FSTART, 32'd0, 16'd0, 24'd0, 16'd0,
                                     64'h0123_4567_89ab_cdef, 32'd0,
                                     11, 128'h00_09_02_ef_cd_ab_89_67_45_23_01));
        directed.push_back(make_word(OPER_FEND, 32'd0, 16'd0, 24'd0, 16'd0, 64'd0, 32'd0,
                                     2, 128'h02_00));
        directed.push_back(make_word(OPER_EOS, 32'd0, 16'd0, 24'd0, 16'd0, 64'd0, 32'd0,
                                     3, 128'h00_01_01));
        directed.push_back(make_word(OPER_ROW, 32'hffff_ffff, 16'd65534, 24'hff_ffff,
                                     16'hffff, 64'd0, 32'd0, 16,
                                     128'h04_ff_ff_03_02_ff_ff_ff_ff_0f_03_fe_ff_ff_07_01));
        directed.push_back(make_word(OPER_ROW, 32'hffff_ffff, 16'd65534, 24'hff_ffff,
                                     16'hffff, 64'd0, 32'd0, 5, 128'h05_ff_ff_03_11));
        directed.push_back(make_word(OPER_FEND, 32'd0, 16'd0, 24'd0, 16'd0, 64'd0, 32'd0,
                                     2, 128'h02_01));
        directed.push_back(make_word(OPER_ROW, 32'd0, 16'd0, 24'd0, 16'd0, 64'd0, 32'd0,
                                     0, '0));
        directed.push_back(make_word(OPER_EOS, 32'd0, 16'd0, 24'd0, 16'd0, 64'd0, 32'd0,
                                     3, 128'h00_01_01));
        // special opcode limits and leb128 sign boundaries
        directed.push_back(make_word(OPER_ROW, 32'd0, 16'd0, 24'd100, 16'd0, 64'd0, 32'd0,
                                     0, '0));
        directed.push_back(make_word(OPER_ROW, 32'd20, 16'd0, 24'd97, 16'd0, 64'd0, 32'd0,
                                     0, '0));
        directed.push_back(make_word(OPER_ROW, 32'd40, 16'd0, 24'd95, 16'd0, 64'd0, 32'd0,
                                     0, '0));
        directed.push_back(make_word(OPER_ROW, 32'd40, 16'd0, 24'd102, 16'd0, 64'd0, 32'd0,
                                     0, '0));
        directed.push_back(make_word(OPER_ROW, 32'd40, 16'd0, 24'd110, 16'd0, 64'd0, 32'd0,
                                     0, '0));
        directed.push_back(make_word(OPER_ROW, 32'd61, 16'd0, 24'd110, 16'd0, 64'd0, 32'd0,
                                     0, '0));
        directed.push_back(make_word(OPER_ROW, 32'd61, 16'd0, 24'd46, 16'd0, 64'd0, 32'd0,
                                     0, '0));
        directed.push_back(make_word(OPER_ROW, 32'd61, 16'd0, 24'd109, 16'd0, 64'd0, 32'd0,
                                     0, '0));
        directed.push_back(make_word(OPER_ROW, 32'd61, 16'd0, 24'd173, 16'd0, 64'd0, 32'd0,
                                     0, '0));
        directed.push_back(make_word(OPER_ROW, 32'd61, 16'd0, 24'd108, 16'd0, 64'd0, 32'd0,
                                     0, '0));
        // column only on same file and line, forced back to zero otherwise
        directed.push_back(make_word(OPER_ROW, 32'd61, 16'd0, 24'd108, 16'd7, 64'd0, 32'd0,
                                     0, '0));
        directed.push_back(make_word(OPER_ROW, 32'd61, 16'd3, 24'd108, 16'd7, 64'd0, 32'd0,
                                     0, '0));
        // function end below the current address wraps
        directed.push_back(make_word(OPER_FEND, 32'd0, 16'd0, 24'd0, 16'd0, 64'd0, 32'd10,
                                     0, '0));
        directed.push_back(make_word(OPER_FSTART, 32'd0, 16'd0, 24'd0, 16'd0, '1, 32'd0,
                                     0, '0));
        directed.push_back(make_word(OPER_ROW, 32'h1234_5678, 16'd3, 24'd108, 16'd0, 64'd0,
                                     32'd0, 0, '0));
        directed.push_back(make_word(OPER_EOS, 32'd0, 16'd0, 24'd0, 16'd0, 64'd0, 32'd0,
                                     0, '0));

        @(posedge rst_n);
        @(negedge clk);
        foreach (directed[i])
            send_word(directed[i]);

        // random phases, one pointer width each, written while idle
        foreach (ptr_settings[p])
        begin
            end_burst();
            wait_drained();
            write_ptr_width(ptr_settings[p]);
            widths_used++;
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
            begin
                if ($urandom_range(99) < 85)
                    send_function();
                else
                    send_noise();
            end
        end
        end_burst();
        wait_drained();

        if (program_bytes.size() != 0)
        begin
            $error("%0d predicted bytes never arrived", program_bytes.size());
            mismatches++;
        end
        $display("covered %0d words: %0d rows, %0d function starts, %0d ends, %0d sequence ends",
                 words_sent, op_seen[OPER_ROW], op_seen[OPER_FSTART], op_seen[OPER_FEND],
                 op_seen[OPER_EOS]);
        $display("checked %0d program bytes over %0d pointer width settings",
                 bytes_checked, widths_used);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== line_table_opcode_encoder.f =====
design/lto_pkg.sv
design/lto_seq.sv
design/lto_dp.sv
design/line_table_opcode_encoder.sv
tb/testbench.sv
